// File: rtl/core/tcce_pkg.sv
// Shared types, constants and helper functions for the text console cursor engine.
// Used by tcce_front, tcce_back and text_console_cursor_engine; depends on nothing.
package tcce_pkg;

   localparam int COLUMNS     = 80;
   localparam int VIEW_ROWS   = 25;
   localparam int BUFFER_ROWS = 256;

   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(BUFFER_ROWS);
   localparam int VIEW_W  = 8;
   localparam int ADDR_W  = 15;
   localparam int OFS_W   = 16;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int OP_W    = 2;
   localparam int POSX_W  = 7;
   localparam int POSY_W  = 8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OP_W-1:0]   OP_PRINT     = 2'd0;
   localparam logic [OP_W-1:0]   OP_BACK      = 2'd1;
   localparam logic [OP_W-1:0]   OP_SETPOS    = 2'd2;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

   typedef enum logic [2:0] {
      CMD_NOP     = 3'd0,
      CMD_PRINT   = 3'd1,
      CMD_NEWLINE = 3'd2,
      CMD_BACK    = 3'd3,
      CMD_SETPOS  = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [CHAR_W-1:0]       char_code;
      logic [COL_W-1:0]        column;
      logic [ROW_W-1:0]        row;
   } cmd_type;

   typedef struct packed {
      logic valid;
   } link_type;

   function automatic logic [ROW_W-1:0] row_mod(input logic [POSY_W-1:0] y);
      logic [POSY_W:0] r;
      r = {1'b0, y};
      for (int i = 0; i < 4; i++) begin
         if (r >= (POSY_W + 1)'(BUFFER_ROWS)) begin
            r = r - (POSY_W + 1)'(BUFFER_ROWS);
         end
      end
      return r[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(row) * ADDR_W'(COLUMNS);
      return base + ADDR_W'(col);
   endfunction

endpackage

// File: rtl/core/text_console_cursor_engine.sv
// Top level of the text console cursor engine: joins the decode front, the command
// queue and the execute back. Depends on tcce_pkg, tcce_front and tcce_back.
//
// Each request beat carries an operation (print, backspace, set position) and its
// operands; each produces exactly one response beat, in order, with the cell write
// (if any), the new hardware cursor offset and the current view start row.
// The attribute byte is loaded through csr_wr_en and csr_wr_data; the user must
// do so only while the engine is idle, which the engine does not enforce. It is
// attached to every cell write. A request accepted at an edge is decoded into the
// two-entry command queue; the back part then takes it, executes it and registers
// the response, and response valid rises. Throughput is one beat per cycle while
// rsp_ready is high, set by the cursor update in the back part.
// After reset the cursor, row and view start are zero, the attribute is 7 and both
// queue and response register are empty.
// When the receiver holds rsp_ready low, the response stays registered, the queue
// fills with up to two more commands, and then req_ready drops until beats drain.
module text_console_cursor_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tcce_pkg::OP_W-1:0]     req_op,
   input  logic [tcce_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcce_pkg::POSX_W-1:0]   req_pos_x,
   input  logic [tcce_pkg::POSY_W-1:0]   req_pos_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_cell_write,
   output logic [tcce_pkg::ADDR_W-1:0]   rsp_cell_address,
   output logic [tcce_pkg::CHAR_W-1:0]   rsp_cell_char,
   output logic [tcce_pkg::ATTR_W-1:0]   rsp_cell_attr,
   output logic [tcce_pkg::OFS_W-1:0]    rsp_cursor_offset,
   output logic [tcce_pkg::VIEW_W-1:0]   rsp_view_start_row,
   input  logic                          csr_wr_en,
   input  logic [tcce_pkg::ATTR_W-1:0]   csr_wr_data
);

   tcce_pkg::link_type  cmd_link;
   tcce_pkg::cmd_type   cmd;
   logic                cmd_pop;

   tcce_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_char_code (req_char_code),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .cmd_link_out  (cmd_link),
      .cmd_pop       (cmd_pop),
      .cmd_out       (cmd)
   );

   tcce_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_link_in        (cmd_link),
      .cmd_in             (cmd),
      .cmd_pop            (cmd_pop),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cell_write     (rsp_cell_write),
      .rsp_cell_address   (rsp_cell_address),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attr      (rsp_cell_attr),
      .rsp_cursor_offset  (rsp_cursor_offset),
      .rsp_view_start_row (rsp_view_start_row)
   );

   // A response without a cell write carries zero in the cell fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_cell_write) |->
         (rsp_cell_address == '0 && rsp_cell_char == '0 && rsp_cell_attr == '0))
      else $error("cell fields not cleared on a beat without a cell write");

   // Cell writes stay inside the backing store.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cell_write) |->
         (17'(rsp_cell_address) < 17'(tcce_pkg::BUFFER_ROWS * tcce_pkg::COLUMNS)))
      else $error("cell address beyond the backing store");

   // The back part only takes a command that the queue holds.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_link.valid)
      else $error("command popped from an empty queue");

   // Reset leaves the engine empty and ready for requests.
   assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready && !cmd_link.valid))
      else $error("engine not empty after reset");

endmodule

// File: rtl/core/tcce_front.sv
// Front part of the cursor engine: accepts request beats, decodes them into commands
// and holds them in a short queue for the back part. Depends on tcce_pkg.
module tcce_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tcce_pkg::OP_W-1:0]     req_op,
   input  logic [tcce_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcce_pkg::POSX_W-1:0]   req_pos_x,
   input  logic [tcce_pkg::POSY_W-1:0]   req_pos_y,
   output tcce_pkg::link_type            cmd_link_out,
   input  logic                          cmd_pop,
   output tcce_pkg::cmd_type             cmd_out
);

   tcce_pkg::cmd_type                  queue_ff [tcce_pkg::QUEUE_DEPTH];
   logic [tcce_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [tcce_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [tcce_pkg::QCNT_W-1:0]        count_ff, count_in;
   tcce_pkg::cmd_type                  decoded;
   logic                               push;
   logic                               pop;

   always_comb begin
      decoded.kind      = tcce_pkg::CMD_NOP;
      decoded.char_code = req_char_code;
      decoded.row       = tcce_pkg::row_mod(req_pos_y);
      if (req_pos_x > tcce_pkg::POSX_W'(tcce_pkg::COLUMNS - 1)) begin
         decoded.column = tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
      end else begin
         decoded.column = req_pos_x[tcce_pkg::COL_W-1:0];
      end
      case (req_op)
         tcce_pkg::OP_PRINT: begin
            if (req_char_code == tcce_pkg::NEWLINE_CODE) begin
               decoded.kind = tcce_pkg::CMD_NEWLINE;
            end else begin
               decoded.kind = tcce_pkg::CMD_PRINT;
            end
         end
         tcce_pkg::OP_BACK: begin
            decoded.kind = tcce_pkg::CMD_BACK;
         end
         tcce_pkg::OP_SETPOS: begin
            decoded.kind = tcce_pkg::CMD_SETPOS;
         end
         default: begin
            decoded.kind = tcce_pkg::CMD_NOP;
         end
      endcase
   end

   assign req_ready = (count_ff != tcce_pkg::QCNT_W'(tcce_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign pop       = cmd_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         if (wr_ptr_ff == tcce_pkg::QPTR_W'(tcce_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (pop) begin
         if (rd_ptr_ff == tcce_pkg::QPTR_W'(tcce_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

   assign cmd_link_out.valid = (count_ff != '0);
   assign cmd_out            = queue_ff[rd_ptr_ff];

endmodule

// File: rtl/core/tcce_back.sv
// Back part of the cursor engine: holds the cursor, view and attribute state, executes
// queued commands and drives the registered response beat. Depends on tcce_pkg.
module tcce_back (
   input  logic                          clock,
   input  logic                          reset,
   input  tcce_pkg::link_type            cmd_link_in,
   input  tcce_pkg::cmd_type             cmd_in,
   output logic                          cmd_pop,
   input  logic                          csr_wr_en,
   input  logic [tcce_pkg::ATTR_W-1:0]   csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_cell_write,
   output logic [tcce_pkg::ADDR_W-1:0]   rsp_cell_address,
   output logic [tcce_pkg::CHAR_W-1:0]   rsp_cell_char,
   output logic [tcce_pkg::ATTR_W-1:0]   rsp_cell_attr,
   output logic [tcce_pkg::OFS_W-1:0]    rsp_cursor_offset,
   output logic [tcce_pkg::VIEW_W-1:0]   rsp_view_start_row
);

   logic [tcce_pkg::COL_W-1:0]   col_ff, col_in;
   logic [tcce_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [tcce_pkg::VIEW_W-1:0]  view_ff, view_in;
   logic [tcce_pkg::ATTR_W-1:0]  attr_ff;
   logic                         rsp_valid_ff;
   logic                         write_ff, write_in;
   logic [tcce_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [tcce_pkg::CHAR_W-1:0]  char_ff, char_in;
   logic [tcce_pkg::ATTR_W-1:0]  wattr_ff, wattr_in;
   logic [tcce_pkg::OFS_W-1:0]   ofs_ff, ofs_in;

   logic [tcce_pkg::ROW_W-1:0]   down_row;
   logic [tcce_pkg::VIEW_W-1:0]  down_view;
   logic [tcce_pkg::ROW_W-1:0]   up_row;
   logic [tcce_pkg::VIEW_W-1:0]  up_view;
   logic [tcce_pkg::OFS_W-1:0]   row_diff;
   logic [tcce_pkg::OFS_W-1:0]   row_base;
   logic                         load;

   assign load    = cmd_link_in.valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_pop = load;

   always_comb begin
      if (row_ff == tcce_pkg::ROW_W'(tcce_pkg::BUFFER_ROWS - 1)) begin
         down_row = '0;
      end else begin
         down_row = row_ff + 1'b1;
      end
      down_view = view_ff;
      if (10'(down_row) >= 10'(view_ff) + 10'(tcce_pkg::VIEW_ROWS)) begin
         down_view = view_ff + 1'b1;
      end
      up_row  = row_ff;
      up_view = view_ff;
      if (row_ff != '0) begin
         up_row = row_ff - 1'b1;
         if ((9'(up_row) < 9'(view_ff)) && (view_ff != '0)) begin
            up_view = view_ff - 1'b1;
         end
      end
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      view_in  = view_ff;
      write_in = 1'b0;
      addr_in  = '0;
      char_in  = '0;
      wattr_in = '0;
      case (cmd_in.kind)
         tcce_pkg::CMD_PRINT: begin
            write_in = 1'b1;
            addr_in  = tcce_pkg::cell_addr(row_ff, col_ff);
            char_in  = cmd_in.char_code;
            wattr_in = attr_ff;
            if (col_ff == tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1)) begin
               col_in  = '0;
               row_in  = down_row;
               view_in = down_view;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         tcce_pkg::CMD_NEWLINE: begin
            col_in  = '0;
            row_in  = down_row;
            view_in = down_view;
         end
         tcce_pkg::CMD_BACK: begin
            write_in = 1'b1;
            wattr_in = attr_ff;
            if (col_ff == '0) begin
               col_in  = tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
               row_in  = up_row;
               view_in = up_view;
            end else begin
               col_in = col_ff - 1'b1;
            end
            addr_in = tcce_pkg::cell_addr(row_in, col_in);
         end
         tcce_pkg::CMD_SETPOS: begin
            col_in = cmd_in.column;
            row_in = cmd_in.row;
         end
         default: begin
            col_in = col_ff;
         end
      endcase
      row_diff = tcce_pkg::OFS_W'(row_in) - tcce_pkg::OFS_W'(view_in);
      row_base = row_diff * tcce_pkg::OFS_W'(tcce_pkg::COLUMNS);
      ofs_in   = row_base + tcce_pkg::OFS_W'(col_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         view_ff      <= '0;
         attr_ff      <= tcce_pkg::ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
         if (load) begin
            col_ff       <= col_in;
            row_ff       <= row_in;
            view_ff      <= view_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         write_ff <= write_in;
         addr_ff  <= addr_in;
         char_ff  <= char_in;
         wattr_ff <= wattr_in;
         ofs_ff   <= ofs_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_write     = write_ff;
   assign rsp_cell_address   = addr_ff;
   assign rsp_cell_char      = char_ff;
   assign rsp_cell_attr      = wattr_ff;
   assign rsp_cursor_offset  = ofs_ff;
   assign rsp_view_start_row = view_ff;

endmodule
